FILE: rtl/pgq_pkg.sv
`default_nettype none

package pgq_pkg;

	// Field widths
	localparam int unsigned COORD_W   = 12;
	localparam int unsigned SUM_W     = 32;
	localparam int unsigned DIV_W     = 16;
	localparam int unsigned WIDTH_W   = 13;
	localparam int unsigned ADDR_W    = 26;
	localparam int unsigned CHAN_W    = 8;

	// Fixed-point format of the colour sums and frame limits
	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned MAX_WIDTH = 4096;

	// Rescale of the average to Q16.16 before the square root
	localparam int unsigned UP_SHIFT  = (FRAC_BITS < 16) ? (16 - FRAC_BITS) : 0;
	localparam int unsigned DN_SHIFT  = (FRAC_BITS > 16) ? (FRAC_BITS - 16) : 0;
	localparam int unsigned SCALE_W   = SUM_W + 8;

	// Square root operand and partial remainder
	localparam int unsigned RAD_W     = 2 * CHAN_W;
	localparam int unsigned REM_W     = CHAN_W + 2;

	// Cell counts and end-to-end latency
	localparam int unsigned DIV_STEPS  = SUM_W;
	localparam int unsigned SQRT_STEPS = CHAN_W;
	localparam int unsigned LATENCY    = DIV_STEPS + SQRT_STEPS;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b1;

	// Reset values of the registers
	localparam logic [DIV_W-1:0]   SAMPLE_COUNT_RST = 16'd1;
	localparam logic [WIDTH_W-1:0] FRAME_WIDTH_RST  = 13'd256;

endpackage

`default_nettype wire

FILE: rtl/pgq_div_cell.sv
`default_nettype none

// One restoring division step: brings down one dividend bit, emits one quotient bit
module pgq_div_cell (
	input  wire logic                      clk,
	input  wire logic [pgq_pkg::DIV_W-1:0] divisor,
	input  wire logic [pgq_pkg::DIV_W-1:0] rem_in,
	input  wire logic [pgq_pkg::SUM_W-1:0] word_in,
	output logic      [pgq_pkg::DIV_W-1:0] rem_out,
	output logic      [pgq_pkg::SUM_W-1:0] word_out
);
	import pgq_pkg::*;

	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             fits;
	logic [DIV_W-1:0] rem_q;
	logic [SUM_W-1:0] word_q;

	// trial subtract of the divisor from the shifted remainder
	always_comb begin
		trial = {rem_in, word_in[SUM_W-1]};
		diff  = trial - {1'b0, divisor};
		fits  = (trial >= {1'b0, divisor});
	end

	// word: dividend bits leave at the top, quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		rem_q  <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		word_q <= {word_in[SUM_W-2:0], fits};
	end

	assign rem_out  = rem_q;
	assign word_out = word_q;

endmodule

`default_nettype wire

FILE: rtl/pgq_sqrt_cell.sv
`default_nettype none

// One digit-by-digit square root step: takes two radicand bits, yields one root bit
module pgq_sqrt_cell (
	input  wire logic                       clk,
	input  wire logic [pgq_pkg::RAD_W-1:0]  rad_in,
	input  wire logic [pgq_pkg::REM_W-1:0]  rem_in,
	input  wire logic [pgq_pkg::CHAN_W-1:0] root_in,
	output logic      [pgq_pkg::RAD_W-1:0]  rad_out,
	output logic      [pgq_pkg::REM_W-1:0]  rem_out,
	output logic      [pgq_pkg::CHAN_W-1:0] root_out
);
	import pgq_pkg::*;

	logic [REM_W+1:0]  rem_sh;
	logic [REM_W+1:0]  trial;
	logic [REM_W+1:0]  diff;
	logic              fits;
	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [CHAN_W-1:0] root_q;

	// compare against 4*root + 1
	always_comb begin
		rem_sh = {rem_in, rad_in[RAD_W-1:RAD_W-2]};
		trial  = {2'b00, root_in, 2'b01};
		diff   = rem_sh - trial;
		fits   = (rem_sh >= trial);
	end

	// remainder stays below 2*root+1, so REM_W bits hold it
	always_ff @(posedge clk) begin
		rad_q  <= {rad_in[RAD_W-3:0], 2'b00};
		rem_q  <= fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
		root_q <= {root_in[CHAN_W-2:0], fits};
	end

	assign rad_out  = rad_q;
	assign rem_out  = rem_q;
	assign root_out = root_q;

endmodule

`default_nettype wire

FILE: rtl/pgq_channel.sv
`default_nettype none

// One colour channel: division chain, rescale and clamp, then square root chain
module pgq_channel (
	input  wire logic                       clk,
	input  wire logic [pgq_pkg::DIV_W-1:0]  divisor,
	input  wire logic [pgq_pkg::SUM_W-1:0]  sum,
	output logic      [pgq_pkg::CHAN_W-1:0] level
);
	import pgq_pkg::*;

	logic [DIV_W-1:0]  div_rem  [0:DIV_STEPS];
	logic [SUM_W-1:0]  div_word [0:DIV_STEPS];
	logic [RAD_W-1:0]  sq_rad   [0:SQRT_STEPS];
	logic [REM_W-1:0]  sq_rem   [0:SQRT_STEPS];
	logic [CHAN_W-1:0] sq_root  [0:SQRT_STEPS];
	logic [SCALE_W-1:0] scaled;

	// division chain, MSB first
	assign div_rem[0]  = '0;
	assign div_word[0] = sum;

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		pgq_div_cell u_cell (
			.clk      (clk),
			.divisor  (divisor),
			.rem_in   (div_rem[i]),
			.word_in  (div_word[i]),
			.rem_out  (div_rem[i+1]),
			.word_out (div_word[i+1])
		);
	end

	// rescale to Q16.16; anything at or above 2^16 roots to 256 or more, so clamp
	always_comb begin
		scaled = ({{(SCALE_W-SUM_W){1'b0}}, div_word[DIV_STEPS]} << UP_SHIFT) >> DN_SHIFT;
	end

	assign sq_rad[0]  = (|scaled[SCALE_W-1:RAD_W]) ? '1 : scaled[RAD_W-1:0];
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;

	// square root chain
	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		pgq_sqrt_cell u_cell (
			.clk      (clk),
			.rad_in   (sq_rad[j]),
			.rem_in   (sq_rem[j]),
			.root_in  (sq_root[j]),
			.rad_out  (sq_rad[j+1]),
			.rem_out  (sq_rem[j+1]),
			.root_out (sq_root[j+1])
		);
	end

	assign level = sq_root[SQRT_STEPS];

endmodule

`default_nettype wire

FILE: rtl/pixel_gamma_quantizer_core.sv
`default_nettype none

// Pixel gamma quantizer. Each accepted pixel (start high while busy is low) gives
// one result word, flagged by a one-cycle done strobe: three 8-bit channels
// min(floor(sqrt(floor(sum / sample_count))), 255) and the red-byte address
// 3 * (y * width + x), wrapped to 26 bits. A pixel can be accepted every cycle
// and busy is never raised; results cannot be held back, so the receiver must
// take done words as they come. The pipeline is 32 cells of a one-bit-per-cell
// divider chain followed by 8 cells of a square root chain, each cell one
// register stage. A sample count of zero divides by one; widths above 4096 are
// treated as 4096. Registers are written through cfg_we and are to be changed
// only while no pixel is in flight.
module pixel_gamma_quantizer_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration
	input  wire logic                          cfg_we,
	input  wire logic [pgq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [pgq_pkg::DIV_W-1:0]     cfg_wdata,
	// pixel in
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [pgq_pkg::COORD_W-1:0]   pixel_x,
	input  wire logic [pgq_pkg::COORD_W-1:0]   pixel_y,
	input  wire logic [pgq_pkg::SUM_W-1:0]     red_sum,
	input  wire logic [pgq_pkg::SUM_W-1:0]     green_sum,
	input  wire logic [pgq_pkg::SUM_W-1:0]     blue_sum,
	// result out
	output logic                               done,
	output logic      [pgq_pkg::ADDR_W-1:0]    byte_address,
	output logic      [pgq_pkg::CHAN_W-1:0]    red_out,
	output logic      [pgq_pkg::CHAN_W-1:0]    green_out,
	output logic      [pgq_pkg::CHAN_W-1:0]    blue_out
);
	import pgq_pkg::*;

	localparam int unsigned PROD_W = COORD_W + WIDTH_W;

	logic [DIV_W-1:0]   sample_count_q;
	logic [WIDTH_W-1:0] frame_width_q;
	logic [DIV_W-1:0]   divisor;
	logic [WIDTH_W-1:0] width_eff;
	logic               accept;
	logic [LATENCY-1:0] vld_q;
	logic [PROD_W-1:0]  prod_s1;
	logic [COORD_W-1:0] x_s1;
	logic [ADDR_W-1:0]  lin;
	logic [ADDR_W:0]    addr_full;
	logic [ADDR_W-1:0]  addr_s2;
	logic [ADDR_W-1:0]  addr_q [0:LATENCY-3];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= SAMPLE_COUNT_RST;
			frame_width_q  <= FRAME_WIDTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SAMPLE_COUNT: sample_count_q <= cfg_wdata;
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata[WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	// effective divisor and width
	always_comb begin
		divisor   = (sample_count_q == '0) ? DIV_W'(1) : sample_count_q;
		width_eff = (frame_width_q > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH)
		                                                  : frame_width_q;
	end

	// the chains advance every cycle, so a pixel is taken whenever offered
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// valid line alongside the cell chains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LATENCY-2:0], accept};
		end
	end

	assign done = vld_q[LATENCY-1];

	// address: row product, then times three as shift-and-add
	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(pixel_y) * PROD_W'(width_eff);
		x_s1    <= pixel_x;
	end

	always_comb begin
		lin       = ADDR_W'(prod_s1) + ADDR_W'(x_s1);
		addr_full = {lin, 1'b0} + {1'b0, lin};
	end

	always_ff @(posedge clk) begin
		addr_s2 <= addr_full[ADDR_W-1:0];
	end

	// address delay line to meet the channel results
	always_ff @(posedge clk) begin
		addr_q[0] <= addr_s2;
		for (int k = 1; k < LATENCY - 2; k++) begin
			addr_q[k] <= addr_q[k-1];
		end
	end

	assign byte_address = addr_q[LATENCY-3];

	// colour channels
	pgq_channel u_red (
		.clk     (clk),
		.divisor (divisor),
		.sum     (red_sum),
		.level   (red_out)
	);

	pgq_channel u_green (
		.clk     (clk),
		.divisor (divisor),
		.sum     (green_sum),
		.level   (green_out)
	);

	pgq_channel u_blue (
		.clk     (clk),
		.divisor (divisor),
		.sum     (blue_sum),
		.level   (blue_out)
	);

`ifndef SYNTHESIS
	// every done word traces back to an accepted pixel
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("done without an accepted pixel");

	// every accepted pixel comes out
	a_pixel_delivered: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("accepted pixel not delivered");

	// address lines up with its pixel's coordinates
	a_addr_matches: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (byte_address == ADDR_W'($past(32'(pixel_y) * 32'(width_eff) * 32'd3
		                                      + 32'(pixel_x) * 32'd3, LATENCY))))
		else $error("byte address out of step with pixel");
`endif

endmodule

`default_nettype wire
